@@ design/ujq_pkg.sv @@
// Package for the UTF-16 to quoted JSON UTF-8 block.
// Holds the run descriptor type, the status codes and character constants.
// Used by every module under design/.
package ujq_pkg;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_LONE_LOW      = 2'd1,
        ST_UNPAIRED_HIGH = 2'd2
    } status_t;

    // One run of output bytes caused by one code unit.
    typedef struct packed {
        logic [7:0][7:0] bytes;     // byte 0 goes out first
        logic [2:0]      last_idx;  // index of the final byte of the run
        logic            done;      // final byte closes the string
        status_t         status;
    } desc_t;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6e;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    localparam logic [15:0] CU_QUOTE     = 16'h0022;
    localparam logic [15:0] CU_BACKSLASH = 16'h005c;
    localparam logic [15:0] CU_BS        = 16'h0008;
    localparam logic [15:0] CU_FF        = 16'h000c;
    localparam logic [15:0] CU_LF        = 16'h000a;
    localparam logic [15:0] CU_CR        = 16'h000d;
    localparam logic [15:0] CU_TAB       = 16'h0009;
    localparam logic [15:0] CU_CTRL_MAX  = 16'h001f;
    localparam logic [15:0] CU_ASCII_MAX = 16'h007f;
    localparam logic [15:0] CU_TWO_MAX   = 16'h07ff;

    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;

    localparam logic [7:0] LEAD2 = 8'hc0;
    localparam logic [7:0] LEAD3 = 8'he0;
    localparam logic [7:0] LEAD4 = 8'hf0;
    localparam logic [7:0] CONT  = 8'h80;

    // Lowercase hexadecimal digit for a nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'd0, nib};
        end else begin
            return 8'h57 + {4'd0, nib};
        end
    endfunction

endpackage

@@ design/utf16_to_json_utf8_quoter_top.sv @@
// Top level of the UTF-16 to quoted JSON UTF-8 string converter.
// Instantiates ujq_front, ujq_queue and ujq_back; depends on ujq_pkg.
//
// The block takes a string as a stream of UTF-16 code units on the s_ side,
// one unit per request, with s_tlast marking the final unit of the string,
// and sends the quoted JSON string literal in UTF-8 on the m_ side, one byte
// per request. The opening quote leads the bytes of the first unit and the
// closing quote trails the bytes of the last unit. Quote and backslash are
// escaped with a backslash, backspace, form feed, newline, carriage return and
// tab get their short escapes, other control units become lowercase \u00XX,
// and surrogate pairs become 4-byte UTF-8 sequences. m_tlast marks the final
// byte caused by an input unit. m_tuser[0] marks the closing quote or an error
// byte; m_tuser[2:1] carries the status: 0 ok, 1 lone low surrogate, 2 high
// surrogate without its low half. An error byte (value 0) is the only byte of
// its unit, no closing quote follows it, and the remaining units of that
// string are swallowed up to and including the one marked last; the receiver
// is expected to drop the string. A unit that yields nothing (a high surrogate
// in mid-string, or a swallowed unit) puts no run into the queue. The front
// end takes one unit per cycle into a two-entry descriptor queue while it has
// space, and the back end sends one byte per cycle while m_tready is high. A
// unit yields one to three bytes for ordinary text, up to eight for a control
// character that both opens and closes a string. The back end's byte
// serializer sets the sustained rate.
module utf16_to_json_utf8_quoter_top import ujq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // string_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // run_last
    output logic [2:0]  m_tuser    // [0] string_done, [2:1] status
);

    // Descriptor hand-off from the front end into the queue.
    logic  push;
    logic  space;
    desc_t push_desc;

    // Queue head toward the back end.
    logic  pop;
    logic  avail;
    desc_t head;

    // The front end classifies each unit and keeps the surrogate state; it
    // stalls only when the queue is full.
    ujq_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .code_unit   (s_tdata),
        .string_last (s_tlast),
        .desc_push   (push),
        .desc_space  (space),
        .desc        (push_desc)
    );

    // The queue lets input keep flowing while a long run is still going out.
    ujq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_desc (push_desc),
        .space     (space),
        .pop       (pop),
        .avail     (avail),
        .head      (head)
    );

    // The back end loads the next run in the same cycle the previous run's
    // final byte is taken, so bytes leave without gaps.
    ujq_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_avail  (avail),
        .q_head   (head),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // A closing or error byte always ends its run.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("string end flagged inside a run");

    // Error bytes carry the value zero and end the string.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:1] != ST_OK |-> m_tdata == 8'd0 && m_tuser[0])
        else $error("malformed error byte");

endmodule

@@ design/ujq_front.sv @@
// Front end: accepts code units, tracks surrogate and string state, and turns
// each unit into a run descriptor. Depends on ujq_pkg.
module ujq_front import ujq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] code_unit,
    input  logic        string_last,
    output logic        desc_push,
    input  logic        desc_space,
    output desc_t       desc
);

    logic       high_pending_reg, high_pending_next;
    logic [9:0] high_bits_reg, high_bits_next;
    logic       at_start_reg, at_start_next;
    logic       discarding_reg, discarding_next;

    logic            accept;
    logic            is_high, is_low;
    logic            err;
    status_t         err_status;
    logic [5:0][7:0] pay;
    logic [2:0]      pay_n;
    logic [7:0][7:0] seq;
    logic [3:0]      seq_n;
    logic [20:0]     cp;

    assign s_tready = desc_space;
    assign accept   = s_tvalid && s_tready;
    assign is_high  = (code_unit[15:10] == SURR_HIGH_TAG);
    assign is_low   = (code_unit[15:10] == SURR_LOW_TAG);
    assign cp       = {1'b0, high_bits_reg, code_unit[9:0]} + SUPP_BASE;

    always_comb begin
        err        = 1'b0;
        err_status = ST_OK;
        if (high_pending_reg && !is_low) begin
            err        = 1'b1;
            err_status = ST_UNPAIRED_HIGH;
        end else if (!high_pending_reg && is_low) begin
            err        = 1'b1;
            err_status = ST_LONE_LOW;
        end else if (!high_pending_reg && is_high && string_last) begin
            err        = 1'b1;
            err_status = ST_UNPAIRED_HIGH;
        end
    end

    // Payload bytes of the unit itself, before any quotes.
    always_comb begin
        pay   = '0;
        pay_n = 3'd0;
        if (high_pending_reg) begin
            pay[0] = LEAD4 | {5'd0, cp[20:18]};
            pay[1] = CONT | {2'd0, cp[17:12]};
            pay[2] = CONT | {2'd0, cp[11:6]};
            pay[3] = CONT | {2'd0, cp[5:0]};
            pay_n  = 3'd4;
        end else if (is_high) begin
            pay_n = 3'd0;
        end else if (code_unit <= CU_CTRL_MAX || code_unit == CU_QUOTE
                     || code_unit == CU_BACKSLASH) begin
            pay[0] = CH_BACKSLASH;
            pay_n  = 3'd2;
            case (code_unit)
                CU_QUOTE:     pay[1] = CH_QUOTE;
                CU_BACKSLASH: pay[1] = CH_BACKSLASH;
                CU_BS:        pay[1] = CH_LOWER_B;
                CU_FF:        pay[1] = CH_LOWER_F;
                CU_LF:        pay[1] = CH_LOWER_N;
                CU_CR:        pay[1] = CH_LOWER_R;
                CU_TAB:       pay[1] = CH_LOWER_T;
                default: begin
                    pay[1] = CH_LOWER_U;
                    pay[2] = CH_ZERO;
                    pay[3] = CH_ZERO;
                    pay[4] = hex_digit(code_unit[7:4]);
                    pay[5] = hex_digit(code_unit[3:0]);
                    pay_n  = 3'd6;
                end
            endcase
        end else if (code_unit <= CU_ASCII_MAX) begin
            pay[0] = code_unit[7:0];
            pay_n  = 3'd1;
        end else if (code_unit <= CU_TWO_MAX) begin
            pay[0] = LEAD2 | {3'd0, code_unit[10:6]};
            pay[1] = CONT | {2'd0, code_unit[5:0]};
            pay_n  = 3'd2;
        end else begin
            pay[0] = LEAD3 | {4'd0, code_unit[15:12]};
            pay[1] = CONT | {2'd0, code_unit[11:6]};
            pay[2] = CONT | {2'd0, code_unit[5:0]};
            pay_n  = 3'd3;
        end
    end

    // Wrap the payload in the opening and closing quotes where they apply.
    always_comb begin
        seq   = {16'd0, pay};
        seq_n = {1'b0, pay_n};
        if (at_start_reg) begin
            seq   = {seq[6:0], CH_QUOTE};
            seq_n = seq_n + 4'd1;
        end
        if (string_last) begin
            for (int k = 0; k < 8; k++) begin
                if (seq_n[2:0] == 3'(k)) begin
                    seq[k] = CH_QUOTE;
                end
            end
            seq_n = seq_n + 4'd1;
        end
    end

    always_comb begin
        desc      = '0;
        desc_push = 1'b0;
        if (err) begin
            desc.done   = 1'b1;
            desc.status = err_status;
            desc_push   = accept && !discarding_reg;
        end else begin
            desc.bytes    = seq;
            desc.last_idx = 3'(seq_n - 4'd1);
            desc.done     = string_last;
            desc.status   = ST_OK;
            desc_push     = accept && !discarding_reg && (seq_n != 4'd0);
        end
    end

    always_comb begin
        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        at_start_next     = at_start_reg;
        discarding_next   = discarding_reg;
        if (accept) begin
            if (discarding_reg) begin
                discarding_next = !string_last;
                at_start_next   = string_last;
            end else if (err || string_last) begin
                high_pending_next = 1'b0;
                high_bits_next    = '0;
                at_start_next     = string_last;
                discarding_next   = !string_last;
            end else begin
                at_start_next     = 1'b0;
                high_pending_next = !high_pending_reg && is_high;
                high_bits_next    = (!high_pending_reg && is_high) ? code_unit[9:0] : '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_pending_reg <= 1'b0;
            high_bits_reg    <= '0;
            at_start_reg     <= 1'b1;
            discarding_reg   <= 1'b0;
        end else begin
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
            at_start_reg     <= at_start_next;
            discarding_reg   <= discarding_next;
        end
    end

    // An error run is always a single byte that ends the string.
    assert property (@(posedge aclk) disable iff (!aresetn)
        desc_push && desc.status != ST_OK |-> desc.last_idx == 3'd0 && desc.done)
        else $error("error run is not a single closing result");

    // Nothing leaves the front while the rest of a faulty string is dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        discarding_reg |-> !desc_push)
        else $error("run produced while discarding");

endmodule

@@ design/ujq_queue.sv @@
// Two-entry queue of run descriptors between the front and back ends.
// Depends on ujq_pkg.
module ujq_queue import ujq_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  space,
    input  logic  pop,
    output logic  avail,
    output desc_t head
);

    desc_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg, fill_next;

    assign space = (fill_reg != 2'd2);
    assign avail = (fill_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (!push || space) && (!pop || avail))
        else $error("queue overflow or underflow");

endmodule

@@ design/ujq_back.sv @@
// Back end: holds one run descriptor and sends its bytes one per cycle while m_tready is high.
// Depends on ujq_pkg.
module ujq_back import ujq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_avail,
    input  desc_t      q_head,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [2:0] m_tuser
);

    desc_t      cur_reg;
    logic       valid_reg;
    logic [2:0] idx_reg, idx_next;
    logic       final_byte;
    logic       run_end;

    assign final_byte = (idx_reg == cur_reg.last_idx);
    assign run_end    = valid_reg && m_tready && final_byte;
    assign q_pop      = q_avail && (!valid_reg || run_end);

    assign m_tvalid = valid_reg;
    assign m_tdata  = cur_reg.bytes[idx_reg];
    assign m_tlast  = final_byte;
    assign m_tuser  = {cur_reg.status, cur_reg.done && final_byte};

    always_comb begin
        idx_next = idx_reg;
        if (q_pop) begin
            idx_next = 3'd0;
        end else if (valid_reg && m_tready) begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end else begin
            if (q_pop) begin
                valid_reg <= 1'b1;
            end else if (run_end) begin
                valid_reg <= 1'b0;
            end
            idx_reg <= idx_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> idx_reg <= cur_reg.last_idx)
        else $error("byte index ran past the end of the run");

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !m_tready |=> valid_reg && $stable(idx_reg))
        else $error("run advanced without a completed request");

endmodule

@@ tb/utf16_to_json_utf8_quoter_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for utf16_to_json_utf8_quoter_top: it streams UTF-16 strings in and
// compares every UTF-8 byte of the quoted JSON literal against its own prediction.
// Depends on ujq_pkg and the block's RTL; needs no files or arguments.
module utf16_to_json_utf8_quoter_top_tb;
    import ujq_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int QUIET_LIMIT   = 4000;
    localparam int UNITS_PER_PHASE = 90;
    localparam int SETTLE_CYCLES = 32;

    // One byte of the literal as the result channel should deliver it.
    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       done;
        status_t    status;
    } quote_byte_t;

    // Predicts the byte stream of the quoter and checks the bytes that come out.
    class json_quote_scoreboard;
        quote_byte_t expected_bytes[$];
        int          errors;
        logic        high_pending;
        logic [9:0]  high_bits;
        logic        at_start;
        logic        discarding;
        logic [7:0]  run[$];

        function new();
            errors = 0;
            end_string();
        endfunction

        function void end_string();
            high_pending = 1'b0;
            high_bits    = '0;
            at_start     = 1'b1;
            discarding   = 1'b0;
        endfunction

        function void expect_byte(logic [7:0] data, logic run_last, logic done, status_t st);
            quote_byte_t b;
            b.data     = data;
            b.run_last = run_last;
            b.done     = done;
            b.status   = st;
            expected_bytes.insert(expected_bytes.size(), b);
        endfunction

        function void append_byte(logic [7:0] c);
            run.insert(run.size(), c);
        endfunction

        function void push_escape(logic [7:0] c);
            append_byte(CH_BACKSLASH);
            append_byte(c);
        endfunction

        function logic [7:0] hex_char(logic [3:0] nib);
            return (nib < 4'd10) ? 8'h30 + nib : 8'h61 + nib - 8'd10;
        endfunction

        function void push_utf8(logic [20:0] cp);
            if (cp <= 21'h7f) begin
                append_byte(cp[7:0]);
            end else if (cp <= 21'h7ff) begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end else if (cp <= 21'hffff) begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end else begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
        endfunction

        // Works out the bytes that one accepted code unit causes.
        function void note_unit(logic [15:0] unit, logic last);
            logic    is_high;
            logic    is_low;
            status_t fault;
            is_high = (unit[15:10] == SURR_HIGH_TAG);
            is_low  = (unit[15:10] == SURR_LOW_TAG);
            if (discarding) begin
                if (last) end_string();
                return;
            end
            fault = ST_OK;
            if (high_pending && !is_low) fault = ST_UNPAIRED_HIGH;
            else if (!high_pending && is_low) fault = ST_LONE_LOW;
            else if (!high_pending && is_high && last) fault = ST_UNPAIRED_HIGH;
            if (fault != ST_OK) begin
                // A fault stands alone: no quotes, and the rest of the string is swallowed.
                expect_byte(8'h00, 1'b1, 1'b1, fault);
                high_pending = 1'b0;
                high_bits    = '0;
                if (last) begin
                    end_string();
                end else begin
                    at_start   = 1'b0;
                    discarding = 1'b1;
                end
                return;
            end
            run.delete();
            if (at_start) append_byte(CH_QUOTE);
            at_start = 1'b0;
            if (high_pending) begin
                push_utf8(SUPP_BASE + {1'b0, high_bits, unit[9:0]});
                high_pending = 1'b0;
                high_bits    = '0;
            end else if (is_high) begin
                high_pending = 1'b1;
                high_bits    = unit[9:0];
            end else begin
                case (unit)
                    CU_QUOTE, CU_BACKSLASH: push_escape(unit[7:0]);
                    CU_BS:  push_escape(CH_LOWER_B);
                    CU_FF:  push_escape(CH_LOWER_F);
                    CU_LF:  push_escape(CH_LOWER_N);
                    CU_CR:  push_escape(CH_LOWER_R);
                    CU_TAB: push_escape(CH_LOWER_T);
                    default: begin
                        if (unit <= CU_CTRL_MAX) begin
                            push_escape(CH_LOWER_U);
                            append_byte(CH_ZERO);
                            append_byte(CH_ZERO);
                            append_byte(hex_char(unit[7:4]));
                            append_byte(hex_char(unit[3:0]));
                        end else begin
                            push_utf8({5'd0, unit});
                        end
                    end
                endcase
            end
            for (int i = 0; i < run.size(); i++) begin
                expect_byte(run[i], !last && (i == run.size() - 1), 1'b0, ST_OK);
            end
            if (last) begin
                expect_byte(CH_QUOTE, 1'b1, 1'b1, ST_OK);
                end_string();
            end
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_byte(logic [7:0] data, logic tlast, logic [2:0] tuser);
            quote_byte_t want;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %h arrived with nothing expected", data));
                return;
            end
            want = expected_bytes.pop_front();
            if (data !== want.data)
                report($sformatf("out_byte %h, expected %h", data, want.data));
            if (tlast !== want.run_last)
                report($sformatf("run_last %b, expected %b (byte %h)", tlast, want.run_last,
                                 want.data));
            if (tuser[0] !== want.done)
                report($sformatf("string_done %b, expected %b (byte %h)", tuser[0], want.done,
                                 want.data));
            if (tuser[2:1] !== want.status)
                report($sformatf("status %0d, expected %0d", tuser[2:1], want.status));
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // [15:0] code_unit
    logic        s_tlast  = 1'b0; // string_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [7:0] out_byte
    logic        m_tlast;         // run_last
    logic [2:0]  m_tuser;         // [0] string_done, [2:1] status

    json_quote_scoreboard sb;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;
    int units_sent        = 0;
    int quiet_cycles      = 0;

    utf16_to_json_utf8_quoter_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #CLK_HALF aclk = ~aclk;

    // The receiver stalls at random with the probability of the current phase.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Both channels are sampled at the clock edge, so the values seen are the ones that
    // completed the request. The watchdog ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_unit(s_tdata, s_tlast);
            if (m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("utf16_to_json_utf8_quoter_top regression: fail");
                    $finish;
                end
            end
        end
    end

    // Offers one code unit, after a random idle stretch, and holds it until it is taken.
    task automatic send_unit(input logic [15:0] unit, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        units_sent++;
    endtask

    // Holds the sender back until every predicted byte has come out.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_bytes.size() != 0) @(posedge aclk);
    endtask

    // A random string of one to five symbols. Most symbols are well formed text, escapes
    // and surrogate pairs; a few are arbitrary units or broken surrogates.
    task automatic send_random_string();
        int          n;
        int          kind;
        logic        fin;
        logic [15:0] unit;
        logic [9:0]  low10;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            kind  = $urandom_range(0, 99);
            fin   = (i == n - 1);
            low10 = 10'($urandom);
            if (kind < 28) begin
                send_unit(16'($urandom_range(16'h20, 16'h7e)), fin);
            end else if (kind < 40) begin
                send_unit(16'($urandom_range(0, 31)), fin);
            end else if (kind < 46) begin
                send_unit($urandom_range(0, 1) ? CU_QUOTE : CU_BACKSLASH, fin);
            end else if (kind < 56) begin
                send_unit(16'($urandom_range(16'h7f, 16'h7ff)), fin);
            end else if (kind < 70) begin
                unit = 16'($urandom_range(16'h800, 16'hffff));
                // Move surrogate values up into the range F800-FFFF instead.
                if (unit[15:11] == 5'b11011) unit[13] = 1'b1;
                send_unit(unit, fin);
            end else if (kind < 84) begin
                send_unit({SURR_HIGH_TAG, low10}, 1'b0);
                low10 = 10'($urandom);
                send_unit({SURR_LOW_TAG, low10}, fin);
            end else if (kind < 90) begin
                send_unit(16'($urandom), fin);
            end else if (kind < 95) begin
                send_unit({SURR_LOW_TAG, low10}, fin);
            end else begin
                send_unit({SURR_HIGH_TAG, low10}, fin);
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        sender_idle_pct   = 7;
        receiver_idle_pct = 69;

        // Control unit that both opens and closes a string: the longest run of eight bytes.
        send_unit(16'h0000, 1'b1);
        // Every escape, the control ceiling and the UTF-8 length boundaries in one string.
        send_unit(CU_QUOTE, 1'b0);
        send_unit(CU_BACKSLASH, 1'b0);
        send_unit(CU_BS, 1'b0);
        send_unit(CU_FF, 1'b0);
        send_unit(CU_LF, 1'b0);
        send_unit(CU_CR, 1'b0);
        send_unit(CU_TAB, 1'b0);
        send_unit(CU_CTRL_MAX, 1'b0);
        send_unit(CU_ASCII_MAX, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(CU_TWO_MAX, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hffff, 1'b1);
        // Surrogate pairs at the lowest and highest values: the first one opens the string
        // so its high half yields only the quote, the second one yields nothing until paired.
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b1);
        // High surrogate as the only and last unit: a fault with no opening quote.
        send_unit(16'hdbff, 1'b1);
        // Lone low surrogate on the first unit; the rest of the string is swallowed.
        send_unit(16'hdc00, 1'b0);
        send_unit(16'h0041, 1'b1);
        // High surrogate followed by an ordinary unit in mid-string.
        send_unit(16'h0041, 1'b0);
        send_unit(16'hd9aa, 1'b0);
        send_unit(16'h0042, 1'b1);
        // Lone low surrogate as the last unit of a string already opened.
        send_unit(16'h0030, 1'b0);
        send_unit(16'hdfff, 1'b1);
        wait_for_drain();

        // Three idle patterns; between them the sender waits for the result side to empty.
        for (int phase = 0; phase < 3; phase++) begin
            int goal;
            case (phase)
                0: begin
                    sender_idle_pct   = 7;
                    receiver_idle_pct = 69;
                end
                1: begin
                    sender_idle_pct   = 69;
                    receiver_idle_pct = 7;
                end
                default: begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            goal = units_sent + UNITS_PER_PHASE;
            while (units_sent < goal) send_random_string();
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.expected_bytes.size() != 0)
            sb.report($sformatf("%0d predicted bytes never arrived", sb.expected_bytes.size()));
        if (sb.errors == 0) begin
            $display("utf16_to_json_utf8_quoter_top regression: pass");
        end else begin
            $display("utf16_to_json_utf8_quoter_top regression: fail");
        end
        $finish;
    end

endmodule
